>>> sv/clcd_pkg.sv
// Shared types, codes and tables for the character LCD expander sequencer.
`default_nettype none
package clcd_pkg;

  localparam logic [2:0] OP_CHAR   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_MODE   = 3'd3;
  localparam logic [2:0] OP_GLYPH  = 3'd4;
  localparam logic [2:0] OP_INIT   = 3'd5;
  localparam logic [2:0] OP_RAW    = 3'd6;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;
  localparam logic [7:0] CMD_DISPLAY   = 8'h0C;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic       RS_CMD        = 1'b0;
  localparam logic       RS_DATA       = 1'b1;
  localparam logic       BACKLIGHT     = 1'b1;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd39;
  localparam logic       REG_DEV_ADDR   = 1'b0;

  // logical bytes per job, minus one
  localparam logic [3:0] LAST_IDX_SINGLE = 4'd0;
  localparam logic [3:0] LAST_IDX_GLYPH  = 4'd8;
  localparam logic [3:0] LAST_IDX_INIT   = 4'd7;
  localparam logic [2:0] LAST_PHASE      = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [2:0]  row;
    logic [5:0]  column;
    logic        cursor_on;
    logic        blink_on;
    logic [3:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } req_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic [6:0] bus_address;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_GLYPH,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  cmd;
    logic        rs;
    logic [63:0] rows;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    case (r)
      2'd0:    row_base = 8'h00;
      2'd1:    row_base = 8'h40;
      2'd2:    row_base = 8'h14;
      default: row_base = 8'h54;
    endcase
  endfunction

  function automatic logic [7:0] init_cmd(input logic [2:0] i);
    case (i)
      3'd0, 3'd1, 3'd2: init_cmd = 8'h03;
      3'd3:    init_cmd = 8'h02;
      3'd4:    init_cmd = 8'h2C;
      3'd5:    init_cmd = 8'h0C;
      3'd6:    init_cmd = 8'h06;
      default: init_cmd = 8'h01;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/clcd_front.sv
// Front end: decodes a request into a job descriptor or drops it.
`default_nettype none
module clcd_front (
  input  clcd_pkg::req_t req,
  output logic           job_valid,
  output clcd_pkg::job_t job
);
  import clcd_pkg::*;

  always_comb begin
    job_valid = 1'b1;
    job.kind  = JOB_SINGLE;
    job.cmd   = req.char_code;
    job.rs    = RS_CMD;
    job.rows  = req.glyph_rows;
    case (req.opcode)
      OP_CHAR: begin
        job.rs = RS_DATA;
      end
      OP_CLEAR: begin
        job.cmd = CMD_CLEAR;
      end
      OP_CURSOR: begin
        job_valid = ~req.row[2];
        job.cmd   = CMD_DDRAM | (row_base(req.row[1:0]) + {2'b00, req.column});
      end
      OP_MODE: begin
        job.cmd = CMD_DISPLAY | {6'd0, req.cursor_on, req.cursor_on & req.blink_on};
      end
      OP_GLYPH: begin
        job_valid = ~req.glyph_slot[3];
        job.kind  = JOB_GLYPH;
        job.cmd   = CMD_CGRAM | {2'b00, req.glyph_slot[2:0], 3'b000};
      end
      OP_INIT: begin
        job.kind = JOB_INIT;
      end
      OP_RAW: begin
        job.cmd = req.char_code;
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/clcd_fifo.sv
// Two-entry job queue between the decoder and the byte sequencer.
`default_nettype none
module clcd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  clcd_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           head_valid,
  output clcd_pkg::job_t head_job
);
  import clcd_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

>>> sv/clcd_back.sv
// Back end: walks the head job byte by byte and nibble by nibble.
`default_nettype none
module clcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  clcd_pkg::job_t head_job,
  output logic           head_pop,
  input  logic [6:0]     dev_addr,
  output logic           out_valid,
  output clcd_pkg::res_t out_res,
  input  logic           out_take
);
  import clcd_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  res_t       res_r, res_nxt;

  logic       advance;
  logic [3:0] last_idx;
  logic [7:0] lbyte;
  logic       rs;
  logic [2:0] row_sel;
  logic [3:0] nib;
  logic       en;
  logic       byte_done;
  logic       job_done;

  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    row_sel  = 3'(idx_r - 4'd1);
    last_idx = LAST_IDX_SINGLE;
    lbyte    = head_job.cmd;
    rs       = head_job.rs;
    case (head_job.kind)
      JOB_SINGLE: begin
        last_idx = LAST_IDX_SINGLE;
      end
      JOB_GLYPH: begin
        last_idx = LAST_IDX_GLYPH;
        if (idx_r != 4'd0) begin
          lbyte = head_job.rows[{row_sel, 3'b000} +: 8];
          rs    = RS_DATA;
        end else begin
          rs    = RS_CMD;
        end
      end
      JOB_INIT: begin
        last_idx = LAST_IDX_INIT;
        lbyte    = init_cmd(idx_r[2:0]);
        rs       = RS_CMD;
      end
      default: begin
        last_idx = LAST_IDX_SINGLE;
      end
    endcase

    // phases 0..2 carry the high nibble, 3..5 the low; strobe in the middle one
    nib       = (phase_r < 3'd3) ? lbyte[7:4] : lbyte[3:0];
    en        = (phase_r == 3'd1) || (phase_r == 3'd4);
    byte_done = (phase_r == LAST_PHASE);
    job_done  = byte_done && (idx_r == last_idx);

    advance   = head_valid && (!valid_r || out_take);
    head_pop  = advance && job_done;

    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    valid_nxt = valid_r && !out_take;
    res_nxt   = res_r;
    if (advance) begin
      valid_nxt                 = 1'b1;
      res_nxt.expander_byte     = {nib, BACKLIGHT, en, 1'b0, rs};
      res_nxt.bus_address       = dev_addr;
      res_nxt.last              = job_done;
      if (byte_done) begin
        phase_nxt = 3'd0;
        idx_nxt   = job_done ? 4'd0 : idx_r + 4'd1;
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 4'd0;
      phase_r <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

>>> sv/char_lcd_expander_command_sequencer_top.sv
// Character LCD expander sequencer: register port, decoder, job queue, sequencer.
// Turns display requests into the byte stream for an 8-bit port expander that
// drives a character LCD controller in 4-bit mode.
// Input channel: a request is taken when push is high and full is low. The
// decoder classifies it in the same cycle and writes it into a two-entry job
// queue; requests that produce nothing (bad row, bad glyph slot, unused opcode)
// are dropped there.
// Result channel: queue-like; while empty is low the oldest byte is on out_res
// and is taken when pop is high. Each logical byte yields six expander bytes.
// The request is written into the job queue, and its first byte is then registered
// in the sequencer's output register. Throughput: one result byte per cycle while
// pop is high; a single-byte request yields 6 expander bytes, initialise 48 and
// define glyph 54, set by the byte/phase counter. A stalled pop freezes the
// sequencer; the queue keeps accepting requests until it holds two.
// Register device_address at byte address 0 (APB, pready always high), reset
// value 39; it is copied into bus_address of every result byte.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`default_nettype none
module char_lcd_expander_command_sequencer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  clcd_pkg::req_t in_req,
  output logic           empty,
  input  logic           pop,
  output clcd_pkg::res_t out_res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import clcd_pkg::*;

  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic       cfg_wr;

  logic       job_valid;
  job_t       job;
  logic       q_full;
  logic       head_valid;
  job_t       head_job;
  logic       head_pop;
  logic       out_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEV_ADDR);
  assign prdata = (paddr[2] == REG_DEV_ADDR) ? {25'd0, dev_addr_r} : 32'd0;

  always_comb begin
    dev_addr_nxt = cfg_wr ? pwdata[6:0] : dev_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  assign full  = q_full;
  assign empty = ~out_valid;

  clcd_front u_front (
    .req       (in_req),
    .job_valid (job_valid),
    .job       (job)
  );

  clcd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (push && !q_full && job_valid),
    .wr_job     (job),
    .full       (q_full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  clcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .head_pop   (head_pop),
    .dev_addr   (dev_addr_r),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_take   (pop)
  );

endmodule
`default_nettype wire

>>> dv/char_lcd_expander_command_sequencer_top_tb.sv
// Self-checking testbench for the character LCD expander command sequencer.
`default_nettype none
module char_lcd_expander_command_sequencer_top_tb;
  import clcd_pkg::*;

  localparam logic [2:0] OP_NONE       = 3'd7;
  localparam logic [2:0] ADDR_DEV      = {REG_DEV_ADDR, 2'b00};
  localparam logic [2:0] MAX_ROW       = 3'd3;
  localparam logic [3:0] MAX_SLOT      = 4'd7;
  localparam logic [7:0] ENABLE_MASK   = 8'h04;
  localparam logic [3:0][7:0] DDRAM_BASE = {8'h54, 8'h14, 8'h40, 8'h00};
  localparam logic [7:0][7:0] LCD_WAKEUP =
    {8'h01, 8'h06, 8'h0C, 8'h2C, 8'h02, 8'h03, 8'h03, 8'h03};
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  // Predicts the expander byte stream and checks what comes out.
  class lcd_stream_scoreboard;
    res_t       expected_bytes[$];
    res_t       burst[$];
    logic [6:0] device_address;
    int         errors;
    int         requests;
    int         silent;
    int         checked;

    function new();
      device_address = DEV_ADDR_RESET;
      errors = 0;
      requests = 0;
      silent = 0;
      checked = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    function void stage(logic [7:0] b);
      res_t r;
      r.expander_byte = b;
      r.bus_address = device_address;
      r.last = 1'b0;
      burst.push_back(r);
    endfunction

    function void add_nibble(logic [3:0] nib, logic rs);
      logic [7:0] b;
      b = {nib, BACKLIGHT, 1'b0, 1'b0, rs};
      stage(b);
      stage(b | ENABLE_MASK);
      stage(b & ~ENABLE_MASK);
    endfunction

    function void add_byte(logic [7:0] val, logic rs);
      add_nibble(val[7:4], rs);
      add_nibble(val[3:0], rs);
    endfunction

    function void note_request(req_t r);
      res_t tail;
      burst.delete();
      case (r.opcode)
        OP_CHAR:   add_byte(r.char_code, RS_DATA);
        OP_CLEAR:  add_byte(CMD_CLEAR, RS_CMD);
        OP_CURSOR: begin
          if (r.row <= MAX_ROW)
            add_byte(CMD_DDRAM | (DDRAM_BASE[r.row[1:0]] + {2'b00, r.column}), RS_CMD);
        end
        OP_MODE:   add_byte(CMD_DISPLAY | {6'b0, r.cursor_on, r.cursor_on & r.blink_on},
                            RS_CMD);
        OP_GLYPH: begin
          if (r.glyph_slot <= MAX_SLOT) begin
            add_byte(CMD_CGRAM | {2'b00, r.glyph_slot[2:0], 3'b000}, RS_CMD);
            for (int i = 0; i < 8; i++)
              add_byte(r.glyph_rows[8*i +: 8], RS_DATA);
          end
        end
        OP_INIT: begin
          for (int i = 0; i < 8; i++)
            add_byte(LCD_WAKEUP[i], RS_CMD);
        end
        OP_RAW:    add_byte(r.char_code, RS_CMD);
        default: ;
      endcase
      requests++;
      if (burst.size() == 0) begin
        silent++;
      end else begin
        tail = burst.pop_back();
        tail.last = 1'b1;
        burst.push_back(tail);
        foreach (burst[i])
          expected_bytes.push_back(burst[i]);
      end
    endfunction

    task check_result(res_t got);
      res_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h addr %02h last %0b",
                         got.expander_byte, got.bus_address, got.last));
      end else begin
        want = expected_bytes.pop_front();
        checked++;
        if (got.expander_byte !== want.expander_byte)
          report($sformatf("expander_byte %02h, want %02h",
                           got.expander_byte, want.expander_byte));
        if (got.bus_address !== want.bus_address)
          report($sformatf("bus_address %02h, want %02h",
                           got.bus_address, want.bus_address));
        if (got.last !== want.last)
          report($sformatf("last %0b, want %0b (byte %02h)",
                           got.last, want.last, want.expander_byte));
      end
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  req_t        in_req;
  logic        empty;
  logic        pop = 1'b0;
  res_t        out_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcd_stream_scoreboard sb;
  int unsigned pop_cyc = 0;
  int          burst_left;
  int          reg_writes;
  int unsigned cycle_count = 0;

  char_lcd_expander_command_sequencer_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_req  (in_req),
    .empty   (empty),
    .pop     (pop),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: stall pattern cycles through free-running, light, heavy and bursty modes.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        sb.check_result(out_res);
      pop_cyc <= pop_cyc + 1;
      case (pop_cyc[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= ($urandom_range(0, 3) != 0);
        2'd2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (pop_cyc[6:4] != 3'd0) && (pop_cyc % 5 != 0);
      endcase
    end
  end

  function automatic req_t pack_req(logic [2:0] op, logic [7:0] ch, logic [2:0] row,
                                    logic [5:0] col, logic cur, logic blk,
                                    logic [3:0] slot, logic [63:0] rows);
    req_t r;
    r.opcode = op;
    r.char_code = ch;
    r.row = row;
    r.column = col;
    r.cursor_on = cur;
    r.blink_on = blk;
    r.glyph_slot = slot;
    r.glyph_rows = rows;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = pack_req(3'($urandom), 8'($urandom), 3'($urandom), 6'($urandom),
                 1'($urandom), 1'($urandom), 4'($urandom), {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.opcode = OP_CHAR;
    else if (pick < 38) r.opcode = OP_CLEAR;
    else if (pick < 56) r.opcode = OP_CURSOR;
    else if (pick < 66) r.opcode = OP_MODE;
    else if (pick < 78) r.opcode = OP_GLYPH;
    else if (pick < 84) r.opcode = OP_INIT;
    else if (pick < 96) r.opcode = OP_RAW;
    else                r.opcode = OP_NONE;
    // mostly valid rows and slots, a few out of range
    if ($urandom_range(0, 9) != 0) r.row = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 9) != 0) r.glyph_slot = 4'($urandom_range(0, 7));
    return r;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    in_req <= r;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_request(r);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 60);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  task automatic cfg_read_check(logic [2:0] addr, logic [6:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[6:0] !== want)
      sb.report($sformatf("device_address reads %02h, want %02h", prdata[6:0], want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_device_address(logic [6:0] a);
    cfg_write(ADDR_DEV, {25'b0, a});
    @(posedge clk);
    cfg_read_check(ADDR_DEV, a);
    sb.device_address = a;
  endtask

  task automatic random_phase(int n);
    repeat (n) send_request(random_request());
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("char_lcd_expander_command_sequencer_top_tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    burst_left = $urandom_range(1, 12);
    reg_writes = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read_check(ADDR_DEV, DEV_ADDR_RESET);

    // directed: field extremes, every opcode, out-of-range row and slot, unused opcode
    send_request(pack_req(OP_CHAR, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CHAR, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd15, '1));
    send_request(pack_req(OP_CHAR, 8'h5A, 3'd2, 6'd21, 1'b0, 1'b1, 4'd5, '0));
    send_request(pack_req(OP_CLEAR, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CURSOR, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CURSOR, 8'hFF, 3'd1, 6'd39, 1'b1, 1'b1, 4'd15, '1));
    send_request(pack_req(OP_CURSOR, 8'h00, 3'd2, 6'd63, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CURSOR, 8'h00, 3'd3, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    // column past the visible range still just adds to the base
    send_request(pack_req(OP_CURSOR, 8'h00, 3'd3, 6'd63, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CURSOR, 8'h00, 3'd4, 6'd5, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_CURSOR, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd15, '1));
    send_request(pack_req(OP_MODE, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_MODE, 8'h00, 3'd0, 6'd0, 1'b0, 1'b1, 4'd0, '0));
    send_request(pack_req(OP_MODE, 8'h00, 3'd0, 6'd0, 1'b1, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_MODE, 8'h00, 3'd0, 6'd0, 1'b1, 1'b1, 4'd0, '0));
    send_request(pack_req(OP_GLYPH, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_GLYPH, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd7, '1));
    send_request(pack_req(OP_GLYPH, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd8,
                          64'h0123_4567_89AB_CDEF));
    send_request(pack_req(OP_GLYPH, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd15, '1));
    send_request(pack_req(OP_INIT, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_RAW, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 4'd0, '0));
    send_request(pack_req(OP_RAW, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd15, '1));
    send_request(pack_req(OP_NONE, 8'hFF, 3'd7, 6'd63, 1'b1, 1'b1, 4'd15, '1));
    drain();

    set_device_address(7'h7F);
    random_phase(35);
    drain();

    set_device_address(7'h00);
    random_phase(36);
    drain();

    set_device_address(7'($urandom_range(1, 126)));
    random_phase(36);
    drain();

    $display("Covered %0d requests (%0d with no output) and %0d checked expander bytes,",
             sb.requests, sb.silent, sb.checked);
    $display("across %0d device_address writes including both extremes.", reg_writes);
    if (sb.errors == 0)
      $display("char_lcd_expander_command_sequencer_top_tb: PASS");
    else
      $display("char_lcd_expander_command_sequencer_top_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
